/* rtl/hhlp_pkg.sv */
// hhlp_pkg: shared types and constants for the http header line parser
// no dependencies; used by hhlp_step and http_header_line_parser
package hhlp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OFFS_W  = 12;
    localparam int unsigned COUNT_W = 13;

    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    localparam logic [OFFS_W-1:0] MAX_OFFSET_RESET = 12'd255;

    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_KEY    = 4'd1,
        ST_COLON  = 4'd2,
        ST_SPACE  = 4'd3,
        ST_VALUE  = 4'd4,
        ST_CR     = 4'd5,
        ST_LF     = 4'd6,
        ST_END_CR = 4'd7
    } parse_state_t;

    typedef enum logic [2:0] {
        TK_SEP        = 3'd0,
        TK_KEY        = 3'd1,
        TK_VALUE      = 3'd2,
        TK_KEY_END    = 3'd3,
        TK_LINE_DONE  = 3'd4,
        TK_BLOCK_DONE = 3'd5,
        TK_ERROR      = 3'd6
    } token_kind_t;

    typedef struct packed {
        parse_state_t        next_state;
        logic [COUNT_W-1:0]  next_count;
        token_kind_t         kind;
    } step_result_t;

endpackage

/* rtl/hhlp_step.sv */
// hhlp_step: one byte of header parsing, next state, value count and token class
// depends on hhlp_pkg
module hhlp_step
(
    input  hhlp_pkg::parse_state_t               state,
    input  logic [hhlp_pkg::COUNT_W-1:0]         count,
    input  logic [hhlp_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                 restart,
    input  logic [hhlp_pkg::OFFS_W-1:0]          max_offset,
    output hhlp_pkg::step_result_t               result
);

    hhlp_pkg::parse_state_t        eff_state;
    logic [hhlp_pkg::COUNT_W-1:0]  eff_count;
    hhlp_pkg::token_kind_t         kind;
    logic [hhlp_pkg::COUNT_W-1:0]  count_out;
    hhlp_pkg::parse_state_t        state_out;
    logic                          is_cr;
    logic                          is_lf;
    logic                          too_long;

    assign eff_state = restart ? hhlp_pkg::ST_START : state;
    assign eff_count = restart ? '0 : count;
    assign is_cr     = (data_byte == hhlp_pkg::CH_CR);
    assign is_lf     = (data_byte == hhlp_pkg::CH_LF);
    assign too_long  = (eff_count > {1'b0, max_offset});

    // token class and value count
    always_comb
    begin
        kind      = hhlp_pkg::TK_SEP;
        count_out = eff_count;
        unique case (eff_state)
            hhlp_pkg::ST_KEY:
            begin
                if (data_byte == hhlp_pkg::CH_COLON)
                    kind = hhlp_pkg::TK_KEY_END;
                else if (is_cr || is_lf)
                    kind = hhlp_pkg::TK_ERROR;
                else
                    kind = hhlp_pkg::TK_KEY;
            end
            hhlp_pkg::ST_COLON:
            begin
                kind = (data_byte == hhlp_pkg::CH_SPACE) ? hhlp_pkg::TK_SEP
                                                         : hhlp_pkg::TK_ERROR;
            end
            hhlp_pkg::ST_SPACE:
            begin
                kind      = hhlp_pkg::TK_VALUE;
                count_out = hhlp_pkg::COUNT_W'(1);
            end
            hhlp_pkg::ST_VALUE:
            begin
                if (is_cr)
                    kind = hhlp_pkg::TK_SEP;
                else if (too_long)
                    kind = hhlp_pkg::TK_ERROR;
                else
                begin
                    kind      = hhlp_pkg::TK_VALUE;
                    count_out = eff_count + hhlp_pkg::COUNT_W'(1);
                end
            end
            hhlp_pkg::ST_CR:
            begin
                kind = is_lf ? hhlp_pkg::TK_LINE_DONE : hhlp_pkg::TK_ERROR;
            end
            hhlp_pkg::ST_LF:
            begin
                if (is_cr)
                    kind = hhlp_pkg::TK_SEP;
                else
                begin
                    kind      = hhlp_pkg::TK_KEY;
                    count_out = '0;
                end
            end
            hhlp_pkg::ST_END_CR:
            begin
                kind = is_lf ? hhlp_pkg::TK_BLOCK_DONE : hhlp_pkg::TK_ERROR;
                if (is_lf)
                    count_out = '0;
            end
            default:
            begin
                if (is_cr || is_lf)
                    kind = hhlp_pkg::TK_SEP;
                else
                begin
                    kind      = hhlp_pkg::TK_KEY;
                    count_out = '0;
                end
            end
        endcase
        if (kind == hhlp_pkg::TK_ERROR)
            count_out = '0;
    end

    // next state
    always_comb
    begin
        state_out = eff_state;
        if (kind == hhlp_pkg::TK_ERROR)
            state_out = hhlp_pkg::ST_START;
        else
        begin
            unique case (eff_state)
                hhlp_pkg::ST_KEY:
                    if (data_byte == hhlp_pkg::CH_COLON)
                        state_out = hhlp_pkg::ST_COLON;
                hhlp_pkg::ST_COLON:
                    state_out = hhlp_pkg::ST_SPACE;
                hhlp_pkg::ST_SPACE:
                    state_out = hhlp_pkg::ST_VALUE;
                hhlp_pkg::ST_VALUE:
                    if (is_cr)
                        state_out = hhlp_pkg::ST_CR;
                hhlp_pkg::ST_CR:
                    state_out = hhlp_pkg::ST_LF;
                hhlp_pkg::ST_LF:
                    state_out = is_cr ? hhlp_pkg::ST_END_CR : hhlp_pkg::ST_KEY;
                hhlp_pkg::ST_END_CR:
                    state_out = hhlp_pkg::ST_START;
                default:
                    state_out = (is_cr || is_lf) ? hhlp_pkg::ST_START
                                                 : hhlp_pkg::ST_KEY;
            endcase
        end
    end

    assign result.next_state = state_out;
    assign result.next_count = count_out;
    assign result.kind       = kind;

endmodule

/* rtl/http_header_line_parser.sv */
// http_header_line_parser: classifies header block bytes, one result beat per input beat
// each accepted input beat is registered in the input stage, then in the result stage
// throughput: one byte per cycle unless m_axis_tready stalls; set by the state and count loop
// reset (rst_n low, asynchronous): parser in start state, value count zero,
//   max_value_offset back to 255, both pipeline stages empty
// depends on hhlp_pkg and hhlp_step
module http_header_line_parser
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] restart

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] byte_echo, [20:8] value_length, [23:21] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data        // max_value_offset
);

    logic                                in_valid_reg;
    logic [hhlp_pkg::BYTE_W-1:0]         in_byte_reg;
    logic                                in_restart_reg;

    logic                                out_valid_reg;
    logic [hhlp_pkg::BYTE_W-1:0]         out_byte_reg;
    logic [hhlp_pkg::COUNT_W-1:0]        out_len_reg;
    hhlp_pkg::token_kind_t               out_kind_reg;

    hhlp_pkg::parse_state_t              parse_state_reg;
    logic [hhlp_pkg::COUNT_W-1:0]        value_count_reg;
    logic [hhlp_pkg::OFFS_W-1:0]         max_offset_reg;

    hhlp_pkg::step_result_t              step;
    logic                                out_free;
    logic                                advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    hhlp_step u_step
    (
        .state      (parse_state_reg),
        .count      (value_count_reg),
        .data_byte  (in_byte_reg),
        .restart    (in_restart_reg),
        .max_offset (max_offset_reg),
        .result     (step)
    );

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_restart_reg <= s_axis_tuser;
        end
    end

    // parser state and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_state_reg <= hhlp_pkg::ST_START;
            value_count_reg <= '0;
            max_offset_reg  <= hhlp_pkg::MAX_OFFSET_RESET;
        end
        else
        begin
            if (advance)
            begin
                parse_state_reg <= step.next_state;
                value_count_reg <= step.next_count;
            end
            if (cfg_valid && cfg_ready)
                max_offset_reg <= cfg_data;
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= in_byte_reg;
            out_len_reg  <= step.next_count;
            out_kind_reg <= step.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_len_reg, out_byte_reg};
    assign m_axis_tuser  = out_kind_reg;

endmodule
